FILE: src/tmis_pkg.sv
`default_nettype none

package tmis_pkg;

    localparam int CODE_CELLS = 1024;
    localparam int DATA_CELLS = 1024;
    localparam int CODE_AW    = $clog2(CODE_CELLS);
    localparam int DATA_AW    = $clog2(DATA_CELLS);
    localparam int DEPTH_W    = $clog2(CODE_CELLS) + 1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_INC   = 8'h2B;
    localparam logic [7:0] CH_DEC   = 8'h2D;
    localparam logic [7:0] CH_OUT   = 8'h2E;
    localparam logic [7:0] CH_IN    = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EXEC = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        U_CLEAR,
        U_IDLE,
        U_ROUTE,
        U_EXEC,
        U_FWD_RD,
        U_FWD_CHK,
        U_BWD_RD,
        U_BWD_CHK,
        U_EMIT
    } step_t;

    typedef enum logic [3:0] {
        DP_CLEAR,
        DP_ACCEPT,
        DP_FETCH,
        DP_EXEC,
        DP_FWD_RD,
        DP_FWD_CHK,
        DP_BWD_RD,
        DP_BWD_CHK,
        DP_EMIT
    } dp_op_t;

    typedef enum logic [2:0] {
        C_CLR_LAST,
        C_ACCEPT,
        C_RUN,
        C_DISPATCH,
        C_IP_LAST,
        C_IP_ZERO,
        C_SCAN_END,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        dp_op_t dp;
        cond_t  cond;
        step_t  on_true;
        step_t  on_false;
    } uword_t;

    // control store
    function automatic uword_t ucode_rom(input step_t s);
        uword_t w;
        begin
            case (s)
                U_CLEAR:   w = '{DP_CLEAR,   C_CLR_LAST, U_IDLE, U_CLEAR};
                U_IDLE:    w = '{DP_ACCEPT,  C_ACCEPT,   U_ROUTE, U_IDLE};
                U_ROUTE:   w = '{DP_FETCH,   C_RUN,      U_EXEC, U_EMIT};
                U_EXEC:    w = '{DP_EXEC,    C_DISPATCH, U_EMIT, U_EMIT};
                U_FWD_RD:  w = '{DP_FWD_RD,  C_IP_LAST,  U_EMIT, U_FWD_CHK};
                U_FWD_CHK: w = '{DP_FWD_CHK, C_SCAN_END, U_EMIT, U_FWD_RD};
                U_BWD_RD:  w = '{DP_BWD_RD,  C_IP_ZERO,  U_EMIT, U_BWD_CHK};
                U_BWD_CHK: w = '{DP_BWD_CHK, C_SCAN_END, U_EMIT, U_BWD_RD};
                U_EMIT:    w = '{DP_EMIT,    C_OUT_FREE, U_IDLE, U_EMIT};
                default:   w = '{DP_EMIT,    C_OUT_FREE, U_IDLE, U_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/tape_machine_interpreter_step.sv
`default_nettype none

// Tape-language interpreter, one instruction per execute transfer. A load transfer writes one
// program byte; an execute transfer runs the instruction at the instruction pointer and
// returns one result. A short microprogram steps a single-port program memory and a
// single-port tape memory. After reset the tape is swept to zero, one cell per cycle, with
// in_ready low. A load, or an execute transfer on a halted machine, goes from the route
// step to the emit step; an instruction goes from the route step, which reads both memories,
// through the execute step to the emit step. A bracket scan adds a read and a check step on
// the program memory port for every program byte it walks, and one more read step when it
// runs off either end of the program memory. in_ready is high only in the idle step, which
// the emit step leads to. The next input is taken while a result still waits in the output
// register; a result not yet taken holds the following one in its emit step.
module tape_machine_interpreter_step
    import tmis_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       op,
    input  wire logic [9:0] code_addr,
    input  wire logic [7:0] code_byte,
    input  wire logic [7:0] in_byte,
    output logic            res_valid,
    input  wire logic       res_ready,
    output logic            out_valid,
    output logic [7:0]      out_byte,
    output logic            input_taken,
    output logic            halted
);

    logic [7:0] code_mem [CODE_CELLS];
    logic [7:0] tape_mem [DATA_CELLS];
    logic [7:0] code_rd_reg;
    logic [7:0] tape_rd_reg;

    step_t               upc_reg, upc_next;
    logic [CODE_AW-1:0]  ip_reg, ip_next;
    logic [DATA_AW-1:0]  cp_reg, cp_next;
    logic [DATA_AW-1:0]  clr_reg, clr_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic                stopped_reg, stopped_next;
    logic                op_reg, op_next;
    logic [7:0]          ibyte_reg, ibyte_next;
    logic                pend_out_reg, pend_out_next;
    logic [7:0]          pend_byte_reg, pend_byte_next;
    logic                pend_taken_reg, pend_taken_next;
    logic                res_valid_reg, res_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                input_taken_reg, input_taken_next;
    logic                halted_reg, halted_next;

    uword_t              uw;
    logic                code_we, code_re, tape_we, tape_re;
    logic [CODE_AW-1:0]  code_waddr, code_raddr;
    logic [DATA_AW-1:0]  tape_waddr;
    logic [7:0]          tape_wdata;
    logic                ip_last, ip_zero, depth_one, out_free, cond_ok, accept;
    logic [CODE_AW-1:0]  ip_adv;
    step_t               disp_step;

    assign uw        = ucode_rom(upc_reg);
    assign ip_last   = (ip_reg == CODE_AW'(CODE_CELLS - 1));
    assign ip_zero   = (ip_reg == '0);
    assign ip_adv    = ip_last ? '0 : ip_reg + CODE_AW'(1);
    assign depth_one = (depth_reg == DEPTH_W'(1));
    assign out_free  = !res_valid_reg || res_ready;
    assign in_ready  = (uw.dp == DP_ACCEPT);
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (code_we)
        begin
            code_mem[code_waddr] <= code_byte;
        end
        if (code_re)
        begin
            code_rd_reg <= code_mem[code_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tape_we)
        begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
        if (tape_re)
        begin
            tape_rd_reg <= tape_mem[cp_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg         <= U_CLEAR;
            ip_reg          <= '0;
            cp_reg          <= '0;
            clr_reg         <= '0;
            depth_reg       <= '0;
            stopped_reg     <= 1'b0;
            pend_out_reg    <= 1'b0;
            pend_taken_reg  <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            upc_reg         <= upc_next;
            ip_reg          <= ip_next;
            cp_reg          <= cp_next;
            clr_reg         <= clr_next;
            depth_reg       <= depth_next;
            stopped_reg     <= stopped_next;
            pend_out_reg    <= pend_out_next;
            pend_taken_reg  <= pend_taken_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        ibyte_reg       <= ibyte_next;
        pend_byte_reg   <= pend_byte_next;
        out_valid_reg   <= out_valid_next;
        out_byte_reg    <= out_byte_next;
        input_taken_reg <= input_taken_next;
        halted_reg      <= halted_next;
    end

    always_comb
    begin
        ip_next          = ip_reg;
        cp_next          = cp_reg;
        clr_next         = clr_reg;
        depth_next       = depth_reg;
        stopped_next     = stopped_reg;
        op_next          = op_reg;
        ibyte_next       = ibyte_reg;
        pend_out_next    = pend_out_reg;
        pend_byte_next   = pend_byte_reg;
        pend_taken_next  = pend_taken_reg;
        res_valid_next   = res_valid_reg && !res_ready;
        out_valid_next   = out_valid_reg;
        out_byte_next    = out_byte_reg;
        input_taken_next = input_taken_reg;
        halted_next      = halted_reg;
        code_we          = 1'b0;
        code_re          = 1'b0;
        code_waddr       = CODE_AW'(code_addr);
        code_raddr       = ip_reg;
        tape_we          = 1'b0;
        tape_re          = 1'b0;
        tape_waddr       = cp_reg;
        tape_wdata       = 8'h00;
        disp_step        = U_EMIT;

        case (uw.dp)
            DP_CLEAR:
            begin
                tape_we    = 1'b1;
                tape_waddr = clr_reg;
                clr_next   = clr_reg + DATA_AW'(1);
            end
            DP_ACCEPT:
            begin
                if (accept)
                begin
                    op_next         = op;
                    ibyte_next      = in_byte;
                    pend_out_next   = 1'b0;
                    pend_byte_next  = 8'h00;
                    pend_taken_next = 1'b0;
                    code_we = (op == OP_LOAD) && (32'(code_addr) < 32'(CODE_CELLS));
                end
            end
            DP_FETCH:
            begin
                code_re = 1'b1;
                tape_re = 1'b1;
            end
            DP_EXEC:
            begin
                ip_next      = ip_adv;
                stopped_next = ip_last;
                case (code_rd_reg)
                    CH_NUL:
                    begin
                        ip_next      = ip_reg;
                        stopped_next = 1'b1;
                    end
                    CH_RIGHT:
                    begin
                        cp_next = (cp_reg == DATA_AW'(DATA_CELLS - 1)) ? '0
                                : cp_reg + DATA_AW'(1);
                    end
                    CH_LEFT:
                    begin
                        cp_next = (cp_reg == '0) ? DATA_AW'(DATA_CELLS - 1)
                                : cp_reg - DATA_AW'(1);
                    end
                    CH_INC:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = tape_rd_reg + 8'd1;
                    end
                    CH_DEC:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = tape_rd_reg - 8'd1;
                    end
                    CH_OUT:
                    begin
                        pend_out_next  = 1'b1;
                        pend_byte_next = tape_rd_reg;
                    end
                    CH_IN:
                    begin
                        tape_we         = 1'b1;
                        tape_wdata      = ibyte_reg;
                        pend_taken_next = 1'b1;
                    end
                    CH_OPEN:
                    begin
                        if (tape_rd_reg == 8'h00)
                        begin
                            ip_next      = ip_reg;
                            stopped_next = 1'b0;
                            depth_next   = DEPTH_W'(1);
                            disp_step    = U_FWD_RD;
                        end
                    end
                    CH_CLOSE:
                    begin
                        if (tape_rd_reg != 8'h00)
                        begin
                            ip_next      = ip_reg;
                            stopped_next = 1'b0;
                            depth_next   = DEPTH_W'(1);
                            disp_step    = U_BWD_RD;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            DP_FWD_RD:
            begin
                if (ip_last)
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    ip_next    = ip_reg + CODE_AW'(1);
                    code_re    = 1'b1;
                    code_raddr = ip_reg + CODE_AW'(1);
                end
            end
            DP_FWD_CHK:
            begin
                case (code_rd_reg)
                    CH_NUL:
                    begin
                        stopped_next = 1'b1;
                    end
                    CH_OPEN:
                    begin
                        depth_next = depth_reg + DEPTH_W'(1);
                    end
                    CH_CLOSE:
                    begin
                        depth_next = depth_reg - DEPTH_W'(1);
                        if (depth_one)
                        begin
                            ip_next      = ip_adv;
                            stopped_next = ip_last;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            DP_BWD_RD:
            begin
                if (ip_zero)
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    ip_next    = ip_reg - CODE_AW'(1);
                    code_re    = 1'b1;
                    code_raddr = ip_reg - CODE_AW'(1);
                end
            end
            DP_BWD_CHK:
            begin
                case (code_rd_reg)
                    CH_CLOSE:
                    begin
                        depth_next = depth_reg + DEPTH_W'(1);
                    end
                    CH_OPEN:
                    begin
                        depth_next = depth_reg - DEPTH_W'(1);
                        if (depth_one)
                        begin
                            ip_next      = ip_adv;
                            stopped_next = ip_last;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            DP_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next   = 1'b1;
                    out_valid_next   = pend_out_reg;
                    out_byte_next    = pend_byte_reg;
                    input_taken_next = pend_taken_reg;
                    halted_next      = stopped_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        case (uw.cond)
            C_CLR_LAST: cond_ok = (clr_reg == DATA_AW'(DATA_CELLS - 1));
            C_ACCEPT:   cond_ok = accept;
            C_RUN:      cond_ok = (op_reg == OP_EXEC) && !stopped_reg;
            C_IP_LAST:  cond_ok = ip_last;
            C_IP_ZERO:  cond_ok = ip_zero;
            C_SCAN_END:
            begin
                if (uw.dp == DP_FWD_CHK)
                begin
                    cond_ok = (code_rd_reg == CH_NUL)
                           || ((code_rd_reg == CH_CLOSE) && depth_one);
                end
                else
                begin
                    cond_ok = (code_rd_reg == CH_OPEN) && depth_one;
                end
            end
            C_OUT_FREE: cond_ok = out_free;
            default:    cond_ok = 1'b0;
        endcase

        if (uw.cond == C_DISPATCH)
        begin
            upc_next = disp_step;
        end
        else
        begin
            upc_next = cond_ok ? uw.on_true : uw.on_false;
        end
    end

    assign res_valid   = res_valid_reg;
    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign input_taken = input_taken_reg;
    assign halted      = halted_reg;

    // halt is sticky until reset
    assert property (@(posedge clk) disable iff (!rst_n) !$fell(stopped_reg))
        else $error("stopped cleared without reset");

    assert property (@(posedge clk) disable iff (!rst_n) (upc_reg == U_CLEAR) |-> !in_ready)
        else $error("input taken during tape clear");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(upc_reg == U_EMIT))
        else $error("result raised outside emit step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && out_valid_reg) |-> !input_taken_reg)
        else $error("output and input in one result");

endmodule

`default_nettype wire

FILE: tb/tape_step_checker.sv
module tape_step_checker
    import tmis_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic               op,
    input  wire logic [9:0]         code_addr,
    input  wire logic [7:0]         code_byte,
    input  wire logic [7:0]         in_byte,
    input  wire logic               res_valid,
    input  wire logic               res_ready,
    input  wire logic               out_valid,
    input  wire logic [7:0]         out_byte,
    input  wire logic               input_taken,
    input  wire logic               halted,
    output int                      fail_count,
    output int                      pending,
    output logic [CODE_AW-1:0]      next_pc,
    output logic                    machine_halted
);

    typedef struct packed {
        logic       emit;
        logic [7:0] emit_byte;
        logic       took_input;
        logic       stop;
    } step_result_t;

    logic [7:0]         tape [0:DATA_CELLS-1];
    logic [7:0]         program_mem [0:CODE_CELLS-1];
    logic [DATA_AW-1:0] cell_ptr;
    step_result_t       expected_results [$];

    task automatic interpret_transfer(
        input  op_t          kind,
        input  logic [9:0]   addr,
        input  logic [7:0]   cbyte,
        input  logic [7:0]   ibyte,
        output step_result_t res
    );
        logic [7:0]  instr;
        logic [7:0]  probe;
        int unsigned pos;
        int unsigned depth;
        bit          scanning;
        bit          found;
        res = '0;
        if (kind == OP_LOAD)
        begin
            program_mem[addr] = cbyte;
        end
        else if (!machine_halted)
        begin
            instr = program_mem[next_pc];
            pos = 32'(next_pc);
            if (instr == CH_NUL)
            begin
                machine_halted = 1'b1;
            end
            else
            begin
                case (instr)
                    CH_RIGHT: cell_ptr = cell_ptr + DATA_AW'(1);
                    CH_LEFT:  cell_ptr = cell_ptr - DATA_AW'(1);
                    CH_INC:   tape[cell_ptr] = tape[cell_ptr] + 8'd1;
                    CH_DEC:   tape[cell_ptr] = tape[cell_ptr] - 8'd1;
                    CH_OUT:
                    begin
                        res.emit = 1'b1;
                        res.emit_byte = tape[cell_ptr];
                    end
                    CH_IN:
                    begin
                        res.took_input = 1'b1;
                        tape[cell_ptr] = ibyte;
                    end
                    CH_OPEN:
                    if (tape[cell_ptr] == 8'd0)
                    begin
                        depth = 1;
                        found = 1'b0;
                        scanning = 1'b1;
                        while (scanning)
                        begin
                            if (pos + 1 >= CODE_CELLS)
                            begin
                                scanning = 1'b0;
                            end
                            else
                            begin
                                pos++;
                                probe = program_mem[pos];
                                if (probe == CH_NUL)
                                    scanning = 1'b0;
                                else if (probe == CH_OPEN)
                                    depth++;
                                else if (probe == CH_CLOSE)
                                begin
                                    depth--;
                                    if (depth == 0)
                                    begin
                                        found = 1'b1;
                                        scanning = 1'b0;
                                    end
                                end
                            end
                        end
                        if (!found)
                            machine_halted = 1'b1;
                    end
                    CH_CLOSE:
                    if (tape[cell_ptr] != 8'd0)
                    begin
                        depth = 1;
                        found = 1'b0;
                        scanning = 1'b1;
                        while (scanning)
                        begin
                            if (pos == 0)
                            begin
                                scanning = 1'b0;
                            end
                            else
                            begin
                                pos--;
                                probe = program_mem[pos];
                                if (probe == CH_CLOSE)
                                    depth++;
                                else if (probe == CH_OPEN)
                                begin
                                    depth--;
                                    if (depth == 0)
                                    begin
                                        found = 1'b1;
                                        scanning = 1'b0;
                                    end
                                end
                            end
                        end
                        if (!found)
                            machine_halted = 1'b1;
                    end
                    default: ;
                endcase
                if (!machine_halted)
                begin
                    if (pos + 1 >= CODE_CELLS)
                    begin
                        next_pc = '0;
                        machine_halted = 1'b1;
                    end
                    else
                    begin
                        next_pc = CODE_AW'(pos + 1);
                    end
                end
            end
        end
        res.stop = machine_halted;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        step_result_t want;
        step_result_t fresh;
        if (!rst_n)
        begin
            for (int i = 0; i < DATA_CELLS; i++)
                tape[i] = 8'd0;
            for (int i = 0; i < CODE_CELLS; i++)
                program_mem[i] = 8'd0;
            cell_ptr = '0;
            next_pc = '0;
            machine_halted = 1'b0;
            expected_results.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("out_valid", 8'(want.emit), 8'(out_valid));
                    check_field("out_byte", want.emit_byte, out_byte);
                    check_field("input_taken", 8'(want.took_input), 8'(input_taken));
                    check_field("halted", 8'(want.stop), 8'(halted));
                end
            end
            if (in_valid && in_ready)
            begin
                interpret_transfer(op_t'(op), code_addr, code_byte, in_byte, fresh);
                expected_results.push_back(fresh);
            end
            pending = expected_results.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
module tb_top;
    import tmis_pkg::*;

    typedef enum int {
        STOP_NUL_BYTE,
        STOP_NO_OPEN,
        STOP_NO_CLOSE,
        STOP_CODE_END
    } stop_cause_t;

    // opening program: wraps, output, input, nested forward skip, stray close,
    // ignored byte, and a two-pass loop that jumps back
    localparam logic [0:16][7:0] WARMUP = {
        CH_DEC, CH_OUT, CH_INC, CH_LEFT, CH_IN, CH_OUT, CH_RIGHT, CH_OPEN,
        CH_OPEN, CH_CLOSE, CH_CLOSE, CH_CLOSE, 8'hFF, CH_IN, CH_OPEN, CH_DEC, CH_CLOSE
    };
    localparam int WARMUP_LEN = 17;
    localparam int LOOP_COUNT_POS = 13;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                op;
    logic [9:0]          code_addr;
    logic [7:0]          code_byte;
    logic [7:0]          in_byte;
    logic                res_valid;
    logic                res_ready;
    logic                out_valid;
    logic [7:0]          out_byte;
    logic                input_taken;
    logic                halted;
    int                  fail_count;
    int                  pending;
    logic [CODE_AW-1:0]  next_pc;
    logic                machine_halted;

    logic [7:0]          program_image [0:CODE_CELLS-1];
    int                  code_end;
    int                  chunk_start;
    int                  loads_sent;
    int                  steps_sent;
    int                  loop_rewrites;
    bit                  idle_off;

    tape_machine_interpreter_step dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .code_addr   (code_addr),
        .code_byte   (code_byte),
        .in_byte     (in_byte),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .input_taken (input_taken),
        .halted      (halted)
    );

    tape_step_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .code_addr      (code_addr),
        .code_byte      (code_byte),
        .in_byte        (in_byte),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .out_valid      (out_valid),
        .out_byte       (out_byte),
        .input_taken    (input_taken),
        .halted         (halted),
        .fail_count     (fail_count),
        .pending        (pending),
        .next_pc        (next_pc),
        .machine_halted (machine_halted)
    );

    function automatic bit is_command(input logic [7:0] b);
        case (b)
            CH_RIGHT, CH_LEFT, CH_INC, CH_DEC, CH_OUT, CH_IN, CH_OPEN, CH_CLOSE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] filler_byte();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        while (is_command(b))
            b = 8'($urandom_range(1, 255));
        return b;
    endfunction

    // any nonzero byte except a bracket
    function automatic logic [7:0] plain_byte();
        case ($urandom_range(0, 6))
            0: return CH_RIGHT;
            1: return CH_LEFT;
            2: return CH_INC;
            3: return CH_DEC;
            4: return CH_OUT;
            5: return CH_IN;
            default: return filler_byte();
        endcase
    endfunction

    function automatic logic [7:0] random_in_byte();
        return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input op_t kind, input logic [9:0] a, input logic [7:0] cb,
                             input logic [7:0] ib);
        if (!idle_off && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        op        <= kind;
        code_addr <= a;
        code_byte <= cb;
        in_byte   <= ib;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        if (kind == OP_LOAD)
            loads_sent++;
        else
            steps_sent++;
    endtask

    task automatic load_code(input int a, input logic [7:0] b);
        program_image[a] = b;
        send_item(OP_LOAD, 10'(a), b, 8'($urandom));
    endtask

    task automatic run_step(input logic [7:0] ib);
        send_item(OP_EXEC, 10'($urandom), 8'($urandom), ib);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("tape_machine_interpreter_step test failed");
        $finish;
    end

    initial
    begin
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (!idle_off && $urandom_range(0, 3) == 0)
                res_ready <= 1'b0;
            else
                res_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    end

    initial
    begin
        int          i;
        int          target;
        int          depth;
        int          len;
        int          steps;
        int          limit;
        int          spot;
        bit          reversed;
        logic [7:0]  b;
        stop_cause_t cause;

        in_valid = 1'b0;
        op = 1'b0;
        code_addr = '0;
        code_byte = '0;
        in_byte = '0;
        rst_n = 1'b0;
        idle_off = 1'b0;
        loads_sent = 0;
        steps_sent = 0;
        loop_rewrites = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < WARMUP_LEN; i++)
            load_code(i, WARMUP[i]);
        code_end = WARMUP_LEN;
        while (int'(next_pc) < code_end && !machine_halted)
            run_step((int'(next_pc) == LOOP_COUNT_POS) ? 8'd2 : 8'hFF);

        // a run that ends at the code end fills the rest of the program memory,
        // so those loads are counted in the budget up front
        cause = stop_cause_t'($urandom_range(0, 3));

        // program grows in bracket-balanced pieces; each piece runs until the pc leaves it
        while (loads_sent + steps_sent
               + ((cause == STOP_CODE_END) ? CODE_CELLS - code_end : 0) < 1800
               && code_end < 960)
        begin
            idle_off = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 2))
            begin
                spot = $urandom_range(0, code_end - 1);
                if (program_image[spot] != CH_OPEN && program_image[spot] != CH_CLOSE)
                    load_code(spot, plain_byte());
            end

            chunk_start = code_end;
            target = $urandom_range(3, 40);
            depth = 0;
            len = 0;
            while (len < target || depth > 0)
            begin
                if (len >= target)
                    b = CH_CLOSE;
                else
                begin
                    case ($urandom_range(0, 9))
                        0: b = (depth < 3 && len + 3 < target) ? CH_OPEN : plain_byte();
                        1: b = (depth > 0) ? CH_CLOSE : plain_byte();
                        default: b = plain_byte();
                    endcase
                end
                if (b == CH_OPEN)
                    depth++;
                if (b == CH_CLOSE)
                    depth--;
                program_image[chunk_start + len] = b;
                len++;
            end
            reversed = 1'($urandom_range(0, 1));
            for (i = 0; i < len; i++)
            begin
                spot = chunk_start + (reversed ? len - 1 - i : i);
                load_code(spot, program_image[spot]);
            end
            code_end += len;

            steps = 0;
            limit = 3 * len + 20;
            while (!machine_halted && int'(next_pc) < code_end)
            begin
                // runaway loop: strip every bracket pair of this piece
                if (steps == limit)
                begin
                    for (i = chunk_start; i < code_end; i++)
                        if (program_image[i] == CH_OPEN || program_image[i] == CH_CLOSE)
                            load_code(i, filler_byte());
                    loop_rewrites++;
                end
                run_step(random_in_byte());
                steps++;
            end
        end

        idle_off = 1'b1;
        case (cause)
            STOP_NUL_BYTE:
            begin
                load_code(code_end, CH_NUL);
                run_step(random_in_byte());
            end
            STOP_NO_OPEN:
            begin
                load_code(code_end, CH_IN);
                load_code(code_end + 1, CH_CLOSE);
                run_step(8'($urandom_range(1, 255)));
                run_step(random_in_byte());
            end
            STOP_NO_CLOSE:
            begin
                load_code(code_end, CH_IN);
                load_code(code_end + 1, CH_OPEN);
                load_code(code_end + 2, CH_NUL);
                run_step(8'h00);
                run_step(random_in_byte());
            end
            default:
            begin
                load_code(code_end, CH_IN);
                load_code(code_end + 1, CH_OPEN);
                for (i = code_end + 2; i < CODE_CELLS - 1; i++)
                    load_code(i, plain_byte());
                load_code(CODE_CELLS - 1, CH_CLOSE);
                run_step(8'h00);
                run_step(random_in_byte());
            end
        endcase

        // stopped machine: steps do nothing, loads do not restart it
        repeat (4)
        begin
            run_step(random_in_byte());
            load_code($urandom_range(0, CODE_CELLS - 1), 8'($urandom));
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (32) @(negedge clk);

        $display("ran %0d program loads and %0d instruction steps, %0d runaway loops cut open",
                 loads_sent, steps_sent, loop_rewrites);
        $display("program ended by %s", cause.name());
        if (fail_count == 0)
            $display("tape_machine_interpreter_step test passed");
        else
            $display("tape_machine_interpreter_step test failed");
        $finish;
    end

endmodule
